FILE: sv/rcpcwa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpcwa_pkg
// shared constants and types for the rc pulse capture and window average block
// ----------------------------------------------------------------------------
package rcpcwa_pkg;

  localparam int RING_DEPTH_DEF = 128;
  localparam int STAMP_BITS_DEF = 32;

  localparam int CMD_W     = 2;
  localparam int TIME_W    = 32;
  localparam int VALUE_W   = 12;
  localparam int WIN_W     = 13;
  localparam int PULSE_W   = 12;
  localparam int SPAN_W    = 23;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  localparam logic [WIN_W-1:0]   WIN_LOW   = 13'd10;
  localparam logic [WIN_W-1:0]   WIN_HIGH  = 13'd5000;
  localparam logic [WIN_W-1:0]   WIN_RESET = 13'd200;
  localparam logic [PULSE_W-1:0] MIN_RESET = 12'd500;
  localparam logic [PULSE_W-1:0] MAX_RESET = 12'd3000;
  localparam logic [SPAN_W-1:0]  US_PER_MS = 23'd1000;

  typedef enum logic [CMD_W-1:0] {
    CMD_RISE  = 2'd0,
    CMD_FALL  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REG_WINDOW    = 2'd0,
    REG_PULSE_MIN = 2'd1,
    REG_PULSE_MAX = 2'd2
  } reg_idx_e;

  typedef enum logic {
    KIND_PULSE = 1'b0,
    KIND_AVG   = 1'b1
  } kind_e;

endpackage

FILE: sv/rc_pulse_capture_window_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_pulse_capture_window_average
// rc pulse width capture from edge events with a windowed average query
//
// input channel (in_valid_i/in_ready_o) takes one command per transaction:
// rising edge, falling edge or average query, each with a microsecond stamp.
// output channel (out_valid_o/out_ready_i) returns a pulse reading after a
// falling edge that closes an armed, in-range pulse, and an average answer
// after every query. a rising edge gives no result, nor does a falling edge
// without a reading; a reading passes from the exec state through done to
// the output register. a query scans the filled ring entries one per cycle
// through the single ram read port, then, if any entry lies in the window,
// runs a restoring divider one quotient bit per cycle.
// in_ready_o is high only while the sequencer is idle.
// the apb port sets window and pulse limits; write only while idle.
// reset clears the capture, the ring fill count and the registers; no
// clearing pass is needed, entries beyond the fill count are never read.
// a stalled receiver holds the result in the output register; a following
// result waits in the sequencer until the output register frees up.
// ----------------------------------------------------------------------------
module rc_pulse_capture_window_average
  import rcpcwa_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CMD_W-1:0]   cmd_i,
  input  logic [TIME_W-1:0]  time_us_i,

  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               kind_o,
  output logic [VALUE_W-1:0] width_us_o,
  output logic               found_o,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int IDX_W   = $clog2(RING_DEPTH);
  localparam int CNT_W   = $clog2(RING_DEPTH + 1);
  localparam int SUM_W   = VALUE_W + CNT_W;
  localparam int DIVC_W  = $clog2(SUM_W);
  localparam int ALU_W   = (STAMP_BITS > CNT_W + 1) ? STAMP_BITS : CNT_W + 1;
  localparam int CMP_W   = (STAMP_BITS > SPAN_W) ? STAMP_BITS : SPAN_W;
  localparam int ENTRY_W = VALUE_W + STAMP_BITS;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e               state_q, state_d;

  logic [WIN_W-1:0]     win_q, win_d;
  logic [SPAN_W-1:0]    span_q, span_d;
  logic [PULSE_W-1:0]   pmin_q, pmin_d;
  logic [PULSE_W-1:0]   pmax_q, pmax_d;

  logic [CMD_W-1:0]     cmd_q, cmd_d;
  logic [STAMP_BITS-1:0] now_q, now_d;
  logic [STAMP_BITS-1:0] rise_q, rise_d;
  logic                 armed_q, armed_d;
  logic [IDX_W-1:0]     slot_q, slot_d;
  logic [CNT_W-1:0]     fill_q, fill_d;

  logic [CNT_W-1:0]     rd_idx_q, rd_idx_d;
  logic                 pend_q, pend_d;
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [SUM_W-1:0]     quo_q, quo_d;
  logic [DIVC_W-1:0]    divc_q, divc_d;

  logic                 res_kind_q, res_kind_d;
  logic [VALUE_W-1:0]   res_value_q, res_value_d;
  logic                 res_found_q, res_found_d;

  logic                 out_valid_q, out_valid_d;
  logic                 kind_q, kind_d;
  logic [VALUE_W-1:0]   value_q, value_d;
  logic                 found_q, found_d;

  logic [ALU_W-1:0]     alu_a, alu_b;
  logic [ALU_W:0]       alu_diff;
  logic                 alu_borrow;
  logic [STAMP_BITS-1:0] alu_mod;

  logic                 ram_we, ram_re;
  logic [ENTRY_W-1:0]   ram_wdata, ram_rdata;
  logic [VALUE_W-1:0]   rd_width;
  logic [STAMP_BITS-1:0] rd_stamp;

  logic                 in_range;
  logic [CNT_W:0]       div_shift;
  logic [WIN_W-1:0]     win_wr;
  logic                 cfg_wr;

  // shared subtractor: pulse width, sample age and divider trial subtract
  assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_borrow = alu_diff[ALU_W];
  assign alu_mod    = alu_diff[STAMP_BITS-1:0];

  assign rd_width  = ram_rdata[ENTRY_W-1:STAMP_BITS];
  assign rd_stamp  = ram_rdata[STAMP_BITS-1:0];
  assign ram_wdata = {alu_mod[VALUE_W-1:0], now_q};
  assign div_shift = {rem_q, quo_q[SUM_W-1]};

  assign in_range = (alu_mod >= STAMP_BITS'(pmin_q)) && (alu_mod <= STAMP_BITS'(pmax_q));

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    unique case (state_q)
      ST_EXEC: begin
        alu_a = ALU_W'(now_q);
        alu_b = ALU_W'(rise_q);
      end
      ST_SCAN: begin
        alu_a = ALU_W'(now_q);
        alu_b = ALU_W'(rd_stamp);
      end
      ST_DIV: begin
        alu_a = ALU_W'(div_shift);
        alu_b = ALU_W'(cnt_q);
      end
      default: begin
      end
    endcase
  end

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    win_wr = pwdata[WIN_W-1:0];
    if (win_wr < WIN_LOW) begin
      win_wr = WIN_LOW;
    end else if (win_wr > WIN_HIGH) begin
      win_wr = WIN_HIGH;
    end
  end

  always_comb begin
    win_d  = win_q;
    span_d = span_q;
    pmin_d = pmin_q;
    pmax_d = pmax_q;
    if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_WINDOW: begin
          win_d  = win_wr;
          span_d = SPAN_W'(win_wr) * US_PER_MS;
        end
        REG_PULSE_MIN: pmin_d = pwdata[PULSE_W-1:0];
        REG_PULSE_MAX: pmax_d = pwdata[PULSE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WINDOW:    prdata = PDATA_W'(win_q);
      REG_PULSE_MIN: prdata = PDATA_W'(pmin_q);
      REG_PULSE_MAX: prdata = PDATA_W'(pmax_q);
      default:       prdata = '0;
    endcase
  end

  // sequencer
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    now_d       = now_q;
    rise_d      = rise_q;
    armed_d     = armed_q;
    slot_d      = slot_q;
    fill_d      = fill_q;
    rd_idx_d    = rd_idx_q;
    pend_d      = 1'b0;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    divc_d      = divc_q;
    res_kind_d  = res_kind_q;
    res_value_d = res_value_q;
    res_found_d = res_found_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    value_d     = value_q;
    found_d     = found_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = cmd_i;
          now_d   = STAMP_BITS'(time_us_i);
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        unique case (cmd_q)
          CMD_RISE: begin
            rise_d  = now_q;
            armed_d = 1'b1;
          end
          CMD_FALL: begin
            armed_d = 1'b0;
            if (armed_q && in_range) begin
              ram_we      = 1'b1;
              slot_d      = (slot_q == IDX_W'(RING_DEPTH - 1)) ? '0 : slot_q + 1'b1;
              if (fill_q != CNT_W'(RING_DEPTH)) begin
                fill_d = fill_q + 1'b1;
              end
              res_kind_d  = KIND_PULSE;
              res_value_d = alu_mod[VALUE_W-1:0];
              res_found_d = 1'b1;
              state_d     = ST_DONE;
            end
          end
          CMD_QUERY: begin
            rd_idx_d = '0;
            sum_d    = '0;
            cnt_d    = '0;
            state_d  = ST_SCAN;
          end
          default: begin
          end
        endcase
      end
      ST_SCAN: begin
        if (rd_idx_q < fill_q) begin
          ram_re   = 1'b1;
          rd_idx_d = rd_idx_q + 1'b1;
          pend_d   = 1'b1;
        end
        if (pend_q) begin
          if (CMP_W'(alu_mod) <= CMP_W'(span_q)) begin
            sum_d = sum_q + SUM_W'(rd_width);
            cnt_d = cnt_q + 1'b1;
          end
        end else if (rd_idx_q >= fill_q) begin
          if (cnt_q == '0) begin
            res_kind_d  = KIND_AVG;
            res_value_d = '0;
            res_found_d = 1'b0;
            state_d     = ST_DONE;
          end else begin
            rem_d   = '0;
            quo_d   = sum_q;
            divc_d  = '0;
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (!alu_borrow) begin
          rem_d = alu_diff[CNT_W-1:0];
        end else begin
          rem_d = div_shift[CNT_W-1:0];
        end
        quo_d  = {quo_q[SUM_W-2:0], !alu_borrow};
        divc_d = divc_q + 1'b1;
        if (divc_q == DIVC_W'(SUM_W - 1)) begin
          res_kind_d  = KIND_AVG;
          res_value_d = quo_d[VALUE_W-1:0];
          res_found_d = 1'b1;
          state_d     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          kind_d      = res_kind_q;
          value_d     = res_value_q;
          found_d     = res_found_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_q       <= WIN_RESET;
      span_q      <= SPAN_W'(WIN_RESET) * US_PER_MS;
      pmin_q      <= MIN_RESET;
      pmax_q      <= MAX_RESET;
      rise_q      <= '0;
      armed_q     <= 1'b0;
      slot_q      <= '0;
      fill_q      <= '0;
      rd_idx_q    <= '0;
      pend_q      <= 1'b0;
      divc_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_q       <= win_d;
      span_q      <= span_d;
      pmin_q      <= pmin_d;
      pmax_q      <= pmax_d;
      rise_q      <= rise_d;
      armed_q     <= armed_d;
      slot_q      <= slot_d;
      fill_q      <= fill_d;
      rd_idx_q    <= rd_idx_d;
      pend_q      <= pend_d;
      divc_q      <= divc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    now_q       <= now_d;
    sum_q       <= sum_d;
    cnt_q       <= cnt_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    res_kind_q  <= res_kind_d;
    res_value_q <= res_value_d;
    res_found_q <= res_found_d;
    kind_q      <= kind_d;
    value_q     <= value_d;
    found_q     <= found_d;
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign width_us_o  = value_q;
  assign found_o     = found_q;

  rcpcwa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

endmodule

FILE: sv/rcpcwa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpcwa_ram
// simple dual port ram, one write port and one read port with registered read
// ----------------------------------------------------------------------------
module rcpcwa_ram #(
  parameter int WIDTH = 44,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
